// ===== hdl/aes128_block_cipher_defines.svh =====
// Assertion macros shared by the cipher block.
`ifndef AES128_BLOCK_CIPHER_DEFINES_SVH
`define AES128_BLOCK_CIPHER_DEFINES_SVH

// Overlapping implication checked at every rising clock edge outside reset.
`define AES_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define AES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/aes_pkg.sv =====
// Shared types, constants and GF(2^8) functions for the AES-128 block.
package aes_pkg;

    localparam int unsigned NUM_ROUNDS = 10;
    localparam int unsigned NUM_WORDS = 44;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned ADDR_W = 6;

    localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
    localparam logic [0:0] CFG_KEY_LOW = 1'b1;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [7:0] byte_t;
    typedef logic [127:0] block_t;

    // Key-schedule start request and busy status used by the cipher round sequencer.
    typedef struct packed {
        logic busy;
        logic start;
    } ks_ctrl_t;

    function automatic byte_t xtime(input byte_t a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic byte_t gmul(input byte_t a, input byte_t b);
        byte_t p;
        byte_t x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = xtime(x);
        end
        gmul = p;
    endfunction

    function automatic byte_t sbox(input byte_t x);
        byte_t r;
        byte_t base;
        byte_t e;
        r = 8'h01;
        base = x;
        e = 8'd254;
        for (int i = 0; i < 8; i++) begin
            if (e[i]) r = gmul(r, base);
            base = gmul(base, base);
        end
        sbox = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
            ^ {r[3:0], r[7:4]} ^ 8'h63;
    endfunction

    function automatic byte_t inv_sbox(input byte_t x);
        byte_t b;
        byte_t r;
        byte_t base;
        byte_t e;
        b = {x[6:0], x[7]} ^ {x[4:0], x[7:5]} ^ {x[1:0], x[7:2]} ^ 8'h05;
        r = 8'h01;
        base = b;
        e = 8'd254;
        for (int i = 0; i < 8; i++) begin
            if (e[i]) r = gmul(r, base);
            base = gmul(base, base);
        end
        inv_sbox = r;
    endfunction

    // Constant lookup tables, built at elaboration.
    function automatic logic [2047:0] build_sbox(input logic inverse);
        logic [2047:0] t;
        for (int i = 0; i < 256; i++) begin
            t[i*8 +: 8] = inverse ? inv_sbox(byte_t'(i)) : sbox(byte_t'(i));
        end
        build_sbox = t;
    endfunction

    localparam logic [2047:0] SBOX_TBL = build_sbox(1'b0);
    localparam logic [2047:0] INV_SBOX_TBL = build_sbox(1'b1);

    function automatic byte_t sb(input byte_t x);
        sb = SBOX_TBL[x*8 +: 8];
    endfunction

    function automatic byte_t isb(input byte_t x);
        isb = INV_SBOX_TBL[x*8 +: 8];
    endfunction

endpackage

// ===== hdl/aes_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module aes_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 44,
    parameter int unsigned AW = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/aes_keysched.sv =====
// Key expansion sequencer: one round-key word per cycle into the word RAM.
module aes_keysched #(
    parameter int unsigned NWORDS = aes_pkg::NUM_WORDS,
    parameter int unsigned AW = aes_pkg::ADDR_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [127:0]        key,
    output logic                busy,
    output logic                we,
    output logic [AW-1:0]       waddr,
    output logic [31:0]         wdata
);

    typedef enum logic [0:0] { S_IDLE, S_RUN } state_t;

    state_t        state_reg;
    logic [AW-1:0] idx_reg;
    logic [7:0]    rc_reg;
    // Sliding window of the last four words.
    logic [31:0]   w_reg [4];
    logic [31:0]   t;
    logic [31:0]   rot;
    logic [31:0]   nw;

    always_comb
    begin
        rot = {w_reg[3][23:0], w_reg[3][31:24]};
        if (idx_reg[1:0] == 2'd0)
            t = {aes_pkg::sb(rot[31:24]) ^ rc_reg, aes_pkg::sb(rot[23:16]),
                 aes_pkg::sb(rot[15:8]), aes_pkg::sb(rot[7:0])};
        else
            t = w_reg[3];
        nw = w_reg[0] ^ t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            rc_reg    <= 8'h01;
            we        <= 1'b0;
            waddr     <= '0;
            wdata     <= '0;
            for (int i = 0; i < 4; i++) w_reg[i] <= '0;
        end
        else if (start)
        begin
            // A new key restarts the expansion, even in the middle of a run.
            state_reg <= S_RUN;
            idx_reg   <= '0;
            rc_reg    <= 8'h01;
            we        <= 1'b0;
            w_reg[0]  <= key[127:96];
            w_reg[1]  <= key[95:64];
            w_reg[2]  <= key[63:32];
            w_reg[3]  <= key[31:0];
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    we <= 1'b0;
                end
                S_RUN:
                begin
                    we    <= 1'b1;
                    waddr <= idx_reg;
                    if (idx_reg < AW'(4))
                    begin
                        wdata <= w_reg[idx_reg[1:0]];
                    end
                    else
                    begin
                        wdata    <= nw;
                        w_reg[0] <= w_reg[1];
                        w_reg[1] <= w_reg[2];
                        w_reg[2] <= w_reg[3];
                        w_reg[3] <= nw;
                        if (idx_reg[1:0] == 2'd0) rc_reg <= aes_pkg::xtime(rc_reg);
                    end
                    if (idx_reg == AW'(NWORDS - 1))
                        state_reg <= S_IDLE;
                    idx_reg <= idx_reg + AW'(1);
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    we        <= 1'b0;
                end
            endcase
        end
    end

    assign busy = (state_reg == S_RUN) || we;

endmodule

// ===== hdl/aes_round.sv =====
// Shared round unit: one forward or inverse AES round on the working block.
module aes_round (
    input  logic               decrypt,
    input  logic               first,
    input  logic               last,
    input  aes_pkg::block_t    din,
    input  aes_pkg::block_t    rkey,
    output aes_pkg::block_t    dout
);

    aes_pkg::byte_t s [16];
    aes_pkg::byte_t a [16];
    aes_pkg::byte_t m [16];
    aes_pkg::byte_t k [16];
    aes_pkg::byte_t o [16];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = din[127 - 8*i -: 8];
            k[i] = rkey[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (decrypt)
                    a[c*4 + r] = aes_pkg::isb(s[((c - r + 4) & 3)*4 + r]);
                else
                    a[c*4 + r] = aes_pkg::sb(s[((c + r) & 3)*4 + r]);
            end
        end
        // Decrypt adds the key before the inverse mix.
        if (decrypt)
            for (int i = 0; i < 16; i++) a[i] = a[i] ^ k[i];
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (decrypt)
                    m[c*4 + r] = aes_pkg::gmul(a[c*4 + r], 8'h0E)
                        ^ aes_pkg::gmul(a[c*4 + ((r+1) & 3)], 8'h0B)
                        ^ aes_pkg::gmul(a[c*4 + ((r+2) & 3)], 8'h0D)
                        ^ aes_pkg::gmul(a[c*4 + ((r+3) & 3)], 8'h09);
                else
                    m[c*4 + r] = aes_pkg::xtime(a[c*4 + r])
                        ^ aes_pkg::xtime(a[c*4 + ((r+1) & 3)]) ^ a[c*4 + ((r+1) & 3)]
                        ^ a[c*4 + ((r+2) & 3)] ^ a[c*4 + ((r+3) & 3)];
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            if (first)
                o[i] = s[i] ^ k[i];
            else if (decrypt)
                o[i] = last ? a[i] : m[i];
            else
                o[i] = (last ? a[i] : m[i]) ^ k[i];
            dout[127 - 8*i -: 8] = o[i];
        end
    end

endmodule

// ===== hdl/aes128_block_cipher.sv =====
// Top level of the AES-128 ECB encrypt/decrypt block.
//
//  channel  | handshake         | payload
//  request  | valid / ready     | operation, block_high, block_low
//  result   | out_valid / out_ready | result_high, result_low
//  config   | cfg_we            | cfg_index, cfg_data
//
// A request runs from acceptance to result through 11 rounds: each round fetches its
// four round-key words from the single-read RAM (registered read, one word a cycle)
// in S_LOAD and then passes through the round unit in S_DONE. The next request is
// taken once the block is back in S_IDLE. After reset, and after a key write, a key
// expansion holds off requests until it has written all the round-key words.
// A stalled result holds in the output register; the next request runs behind it and
// waits in its last round until the result has been delivered.
module aes128_block_cipher #(
    parameter int unsigned NWORDS = aes_pkg::NUM_WORDS,
    parameter int unsigned AW = aes_pkg::ADDR_W
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic        operation,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_high,
    output logic [63:0] result_low,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data
);

`include "aes128_block_cipher_defines.svh"

    typedef enum logic [1:0] { S_INIT, S_IDLE, S_LOAD, S_DONE } state_t;

    state_t            state_reg;
    logic [63:0]       key_high_reg;
    logic [63:0]       key_low_reg;
    logic              kick_reg;
    logic              dec_reg;
    logic [3:0]        rnd_reg;
    logic [2:0]        phase_reg;
    aes_pkg::block_t   blk_reg;
    aes_pkg::block_t   res_reg;
    aes_pkg::block_t   rk_reg;
    aes_pkg::block_t   rnd_out;
    aes_pkg::ks_ctrl_t ks;
    logic              ks_we;
    logic [AW-1:0]     ks_waddr;
    logic [31:0]       ks_wdata;
    logic [AW-1:0]     raddr;
    logic [31:0]       rdata;
    logic [3:0]        key_round;
    logic              finish;

    assign ks.start = kick_reg;

    aes_keysched #(.NWORDS(NWORDS), .AW(AW)) u_ks (
        .clk(clk), .rst_n(rst_n), .start(ks.start),
        .key({key_high_reg, key_low_reg}), .busy(ks.busy),
        .we(ks_we), .waddr(ks_waddr), .wdata(ks_wdata)
    );

    assign key_round = dec_reg ? 4'(aes_pkg::NUM_ROUNDS) - rnd_reg : rnd_reg;
    assign raddr = AW'({key_round, phase_reg[1:0]});

    aes_ram #(.WIDTH(32), .DEPTH(NWORDS), .AW(AW)) u_ram (
        .clk(clk), .we(ks_we), .waddr(ks_waddr), .wdata(ks_wdata),
        .raddr(raddr), .rdata(rdata)
    );

    aes_round u_round (
        .decrypt(dec_reg), .first(rnd_reg == 4'd0),
        .last(rnd_reg == 4'(aes_pkg::NUM_ROUNDS)),
        .din(blk_reg), .rkey(rk_reg), .dout(rnd_out)
    );

    // The last round completes only once the output register is free.
    assign finish = (state_reg == S_DONE) && (rnd_reg == 4'(aes_pkg::NUM_ROUNDS))
        && (!out_valid || out_ready);

    assign ready = (state_reg == S_IDLE) && !ks.busy && !kick_reg;
    assign result_high = res_reg[127:64];
    assign result_low = res_reg[63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            key_high_reg <= '0;
            key_low_reg  <= '0;
            kick_reg     <= 1'b1;
            dec_reg      <= 1'b0;
            rnd_reg      <= '0;
            phase_reg    <= '0;
            out_valid    <= 1'b0;
            blk_reg      <= '0;
            res_reg      <= '0;
            rk_reg       <= '0;
        end
        else
        begin
            kick_reg <= cfg_we;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    aes_pkg::CFG_KEY_HIGH: key_high_reg <= cfg_data;
                    aes_pkg::CFG_KEY_LOW:  key_low_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (finish)
                out_valid <= 1'b1;
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
            unique case (state_reg)
                S_INIT:
                    state_reg <= S_IDLE;
                S_IDLE:
                begin
                    if (valid && ready)
                    begin
                        blk_reg   <= {block_high, block_low};
                        dec_reg   <= operation;
                        rnd_reg   <= '0;
                        phase_reg <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    // Word for phase p arrives in the cycle after its address.
                    if (phase_reg != 3'd0)
                        rk_reg <= {rk_reg[95:0], rdata};
                    if (phase_reg == 3'd4)
                    begin
                        phase_reg <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                        phase_reg <= phase_reg + 3'd1;
                end
                S_DONE:
                begin
                    if (rnd_reg != 4'(aes_pkg::NUM_ROUNDS))
                    begin
                        blk_reg   <= rnd_out;
                        rnd_reg   <= rnd_reg + 4'd1;
                        state_reg <= S_LOAD;
                    end
                    else if (finish)
                    begin
                        blk_reg   <= rnd_out;
                        res_reg   <= rnd_out;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `AES_ASSERT_IMPL(a_ready_idle, ready, state_reg == S_IDLE && !ks.busy, "ready outside idle")
    `AES_ASSERT_NEXT(a_accept_load, valid && ready, state_reg == S_LOAD, "request not started")
    `AES_ASSERT_IMPL(a_no_ks_busy_run, state_reg == S_LOAD, !ks_we, "key RAM written mid-block")
    `AES_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_high), "result dropped")

endmodule

// ===== bench/aes128_checker.sv =====
// Checker for the AES-128 cipher: predicts each result and compares it with the block's output.
module aes128_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    input  logic        ready,
    input  logic        operation,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] result_high,
    input  logic [63:0] result_low,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          blocks_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0]  cur_key_high;
    logic [63:0]  cur_key_low;
    logic [31:0]  sched[44];
    logic [127:0] cipher_q[$];

    function automatic aes_pkg::byte_t ff_dbl(input aes_pkg::byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic aes_pkg::byte_t ff_mul(input aes_pkg::byte_t a,
                                              input aes_pkg::byte_t b);
        aes_pkg::byte_t p;
        aes_pkg::byte_t x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i]) p ^= x;
            x = ff_dbl(x);
        end
        return p;
    endfunction

    function automatic aes_pkg::byte_t ff_recip(input aes_pkg::byte_t a);
        aes_pkg::byte_t r;
        aes_pkg::byte_t sq;
        r = 8'h01;
        sq = a;
        for (int i = 0; i < 8; i++)
        begin
            if (i != 0) r = ff_mul(r, sq);
            sq = ff_mul(sq, sq);
        end
        return r;
    endfunction

    function automatic aes_pkg::byte_t rol8(input aes_pkg::byte_t x, input int n);
        return aes_pkg::byte_t'((x << n) | (x >> (8 - n)));
    endfunction

    function automatic aes_pkg::byte_t fwd_sub(input aes_pkg::byte_t x);
        aes_pkg::byte_t b;
        b = ff_recip(x);
        return b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
    endfunction

    function automatic aes_pkg::byte_t back_sub(input aes_pkg::byte_t x);
        return ff_recip(rol8(x, 1) ^ rol8(x, 3) ^ rol8(x, 6) ^ 8'h05);
    endfunction

    task automatic build_schedule();
        logic [31:0] t;
        aes_pkg::byte_t rc;
        rc = 8'h01;
        sched[0] = cur_key_high[63:32];
        sched[1] = cur_key_high[31:0];
        sched[2] = cur_key_low[63:32];
        sched[3] = cur_key_low[31:0];
        for (int i = 4; i < 44; i++)
        begin
            t = sched[i-1];
            if (i % 4 == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {fwd_sub(t[31:24]) ^ rc, fwd_sub(t[23:16]), fwd_sub(t[15:8]),
                     fwd_sub(t[7:0])};
                rc = ff_dbl(rc);
            end
            sched[i] = sched[i-4] ^ t;
        end
    endtask

    function automatic logic [127:0] cipher_block(input logic dec, input logic [127:0] blk);
        aes_pkg::byte_t s[16];
        aes_pkg::byte_t t[16];
        aes_pkg::byte_t a[4];
        aes_pkg::byte_t v;
        aes_pkg::byte_t fm[4];
        aes_pkg::byte_t im[4];
        logic [127:0] res;
        int rnd;
        fm = '{8'h02, 8'h03, 8'h01, 8'h01};
        im = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
        for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
        for (int step = 0; step < 11; step++)
        begin
            rnd = dec ? 10 - step : step;
            if (step != 0)
            begin
                // Forward: shift, sub, mix. Inverse: shift, sub (mix after key).
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        if (dec) t[((c + r) % 4) * 4 + r] = s[c*4+r];
                        else t[c*4+r] = s[((c + r) % 4) * 4 + r];
                for (int i = 0; i < 16; i++) s[i] = dec ? back_sub(t[i]) : fwd_sub(t[i]);
                if (!dec && rnd != 10)
                    for (int c = 0; c < 4; c++)
                    begin
                        for (int r = 0; r < 4; r++) a[r] = s[c*4+r];
                        for (int r = 0; r < 4; r++)
                        begin
                            v = 8'h00;
                            for (int k = 0; k < 4; k++) v ^= ff_mul(a[k], fm[(k - r + 4) % 4]);
                            s[c*4+r] = v;
                        end
                    end
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    s[c*4+r] ^= sched[rnd*4+c][31-8*r -: 8];
            if (dec && step != 0 && rnd != 0)
                for (int c = 0; c < 4; c++)
                begin
                    for (int r = 0; r < 4; r++) a[r] = s[c*4+r];
                    for (int r = 0; r < 4; r++)
                    begin
                        v = 8'h00;
                        for (int k = 0; k < 4; k++) v ^= ff_mul(a[k], im[(k - r + 4) % 4]);
                        s[c*4+r] = v;
                    end
                end
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
        return res;
    endfunction

    initial
    begin
        errors = 0;
        pending = 0;
        blocks_seen = 0;
        cur_key_high = '0;
        cur_key_low = '0;
        build_schedule();
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == aes_pkg::CFG_KEY_HIGH) cur_key_high = cfg_data;
                else cur_key_low = cfg_data;
                build_schedule();
            end
            if (valid && ready)
                cipher_q = {cipher_q, cipher_block(operation, {block_high, block_low})};
            if (out_valid && out_ready)
            begin
                blocks_seen++;
                if (cipher_q.size() == 0)
                begin
                    $display("%0t: result %h_%h with no request outstanding", $time,
                             result_high, result_low);
                    errors++;
                end
                else
                begin
                    logic [127:0] want;
                    want = cipher_q.pop_front();
                    if (want[127:64] !== result_high)
                    begin
                        $display("%0t: result_high expected %h actual %h", $time,
                                 want[127:64], result_high);
                        errors++;
                    end
                    if (want[63:0] !== result_low)
                    begin
                        $display("%0t: result_low expected %h actual %h", $time,
                                 want[63:0], result_low);
                        errors++;
                    end
                end
            end
        end
        pending = cipher_q.size();
    end
endmodule

// ===== bench/testbench.sv =====
// Top of the AES-128 cipher testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [63:0] cfg_data;
    int          errors;
    int          pending;
    int          blocks_seen;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off;
    int          quiet_cycles;
    logic [127:0] last_result;

    aes128_block_cipher DUT (.*);

    aes128_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a stretch without any accepted request or result ends the run.
    always @(posedge clk)
    begin
        if ((valid && ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("Timeout: nothing accepted for %0d cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
        if (out_valid && out_ready) last_result <= {result_high, result_low};

    // Receiver: random stalls, plus a long hold-off when asked.
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Valid stays up after an accepted request unless the sender idles or drains.
    task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
        while ($urandom_range(99) < send_idle_pct)
        begin
            valid <= 1'b0;
            @(negedge clk);
        end
        valid <= 1'b1;
        operation <= op;
        block_high <= hi;
        block_low <= lo;
        @(posedge clk);
        while (!ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= aes_pkg::CFG_KEY_HIGH;
        cfg_data <= hi;
        @(negedge clk);
        cfg_index <= aes_pkg::CFG_KEY_LOW;
        cfg_data <= lo;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_phase(input int count, input int idle, input int stall);
        logic [63:0] hi;
        logic [63:0] lo;
        logic op;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int n = 0; n < count; n++)
        begin
            op = 1'($urandom_range(1));
            case ($urandom_range(9))
                0: begin hi = '0; lo = rand64(); end
                1: begin hi = '1; lo = '1; end
                // Feed back the last result as a new block.
                2: begin {hi, lo} = last_result; end
                default: begin hi = rand64(); lo = rand64(); end
            endcase
            send_block(op, hi, lo);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        valid = 1'b0;
        operation = aes_pkg::OP_ENCRYPT;
        block_high = '0;
        block_low = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = aes_pkg::CFG_KEY_HIGH;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        quiet_cycles = 0;
        last_result = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed: the all-zero reset key, then the FIPS-197 key, with edge blocks.
        send_block(aes_pkg::OP_ENCRYPT, '0, '0);
        send_block(aes_pkg::OP_DECRYPT, '0, '0);
        send_block(aes_pkg::OP_ENCRYPT, '1, '1);
        send_block(aes_pkg::OP_DECRYPT, '1, '1);
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_block(aes_pkg::OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(aes_pkg::OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        send_block(aes_pkg::OP_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
        send_block(aes_pkg::OP_DECRYPT, 64'h0000000000000001, 64'h8000000000000000);
        // Key with zero bytes inside it, and the all-ones key.
        load_key(64'h00ff000000ff0000, 64'h0000000000000000);
        send_block(aes_pkg::OP_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block(aes_pkg::OP_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
        load_key('1, '1);
        send_block(aes_pkg::OP_ENCRYPT, '0, '1);
        send_block(aes_pkg::OP_DECRYPT, '1, '0);

        load_key(rand64(), rand64());
        random_phase(350, 0, 0);
        load_key(rand64(), rand64());
        random_phase(350, 59, 0);
        load_key('0, rand64());
        random_phase(350, 0, 59);
        load_key(rand64(), rand64());
        random_phase(300, 6, 6);

        // Hold off the receiver long enough that the block stalls its input.
        hold_off = 400;
        send_idle_pct = 0;
        random_phase(100, 0, 0);

        drain();
        $display("Ran %0d cipher blocks in both directions over eight keys,", blocks_seen);
        $display("with sender gaps, receiver stalls and one long result hold-off.");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
